// ===== rtl/core/rtpb_pkg.sv =====
// Shared types and constants of the request to parallel-port bridge.
package rtpb_pkg;

  // Largest payload or reply in bytes.
  localparam logic [3:0] MaxPayload = 4'd8;

  // Reset value of the byte wait timeout.
  localparam logic [15:0] TimeoutReset = 16'd1000;

  // Command codes of an input transaction.
  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdControl = 2'd1;
  localparam logic [1:0] CmdMonitor = 2'd2;

  // Configuration register indexes.
  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgRetry   = 1'b1;

  typedef enum logic [3:0] {
    PhIdle,
    PhAddr,
    PhLen,
    PhData,
    PhRlen,
    PhRdata
  } phase_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTimeout = 2'd1,
    StatusBadLen  = 2'd2
  } status_e;

  // One input transaction.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] request_address;
    logic [3:0]  request_length;
    logic [63:0] request_payload;
    logic        strobe_n;
    logic [7:0]  port_in;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  port_out;
    logic        drive_port;
    logic        wait_pulse;
    logic        interrupt_line;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [3:0]  reply_length;
    logic [63:0] reply_data;
    logic [15:0] wait_remaining;
  } res_t;

endpackage

// ===== rtl/core/rtpb_fsm.sv =====
// Handshake state machine that turns one transaction into one result.
module rtpb_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  rtpb_pkg::req_t      item_i,
  input  logic [15:0]         timeout_ticks_i,
  input  logic                retry_en_i,
  output rtpb_pkg::res_t      result_o
);

  rtpb_pkg::phase_e phase_q, phase_d;
  logic [2:0]       idx_q, idx_d;
  logic [15:0]      cd_q, cd_d;
  logic [31:0]      addr_q, addr_d;
  logic [63:0]      payload_q, payload_d;
  logic [3:0]       len_q, len_d;
  logic             mon_q, mon_d;
  logic             retry_used_q, retry_used_d;
  logic [63:0]      rs_q, rs_d;
  logic [3:0]       rc_q, rc_d;
  logic [15:0]      last_wait_q, last_wait_d;

  // Decoded view of the current transaction.
  logic             busy;
  logic             is_req;
  logic             cd_live;
  logic             timed;
  logic             fire;
  logic [15:0]      cd_new;
  logic [7:0]       port_byte;
  logic             go_wait;
  rtpb_pkg::phase_e wait_phase;
  logic [2:0]       wait_idx;
  logic             fin;
  rtpb_pkg::status_e fin_st;
  logic             retry;
  logic [3:0]       rc_new;
  logic [63:0]      rs_new;
  logic [5:0]       sh;
  logic [3:0]       idx_inc;
  logic [3:0]       len_sat;

  assign busy    = (phase_q inside {rtpb_pkg::PhAddr, rtpb_pkg::PhLen, rtpb_pkg::PhData,
                                    rtpb_pkg::PhRlen, rtpb_pkg::PhRdata});
  assign is_req  = (item_i.cmd == rtpb_pkg::CmdControl) ||
                   (item_i.cmd == rtpb_pkg::CmdMonitor);
  assign cd_live = (cd_q != 16'd0);
  assign timed   = !cd_live || (item_i.strobe_n && (cd_q == 16'd1));
  assign fire    = !cd_live || !item_i.strobe_n || (cd_q == 16'd1);
  assign cd_new  = (cd_live && item_i.strobe_n) ? (cd_q - 16'd1) : cd_q;
  assign sh      = {idx_q, 3'b000};
  assign idx_inc = {1'b0, idx_q} + 4'd1;
  assign len_sat = (item_i.request_length > rtpb_pkg::MaxPayload) ?
                   rtpb_pkg::MaxPayload : item_i.request_length;
  assign retry   = fin && (fin_st != rtpb_pkg::StatusOk) && mon_q && retry_en_i &&
                   !retry_used_q;

  // Work out what the byte that completes in this tick does.
  always_comb begin
    port_byte  = 8'h00;
    go_wait    = 1'b0;
    wait_phase = rtpb_pkg::PhIdle;
    wait_idx   = 3'd0;
    fin        = 1'b0;
    fin_st     = rtpb_pkg::StatusOk;
    rc_new     = rc_q;
    rs_new     = rs_q;
    if (busy && fire) begin
      case (phase_q)
        rtpb_pkg::PhAddr: begin
          port_byte = 8'(addr_q >> {idx_q[1:0], 3'b000});
          if (timed) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusTimeout;
          end else if (idx_q[1:0] != 2'd3) begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhAddr;
            wait_idx   = {1'b0, idx_q[1:0] + 2'd1};
          end else begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhLen;
          end
        end
        rtpb_pkg::PhLen: begin
          port_byte = {4'h0, len_q};
          if (timed) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusTimeout;
          end else if (mon_q) begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhRlen;
          end else if (len_q == 4'd0) begin
            fin = 1'b1;
          end else begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhData;
          end
        end
        rtpb_pkg::PhData: begin
          port_byte = 8'(payload_q >> sh);
          if (timed) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusTimeout;
          end else if (idx_inc < len_q) begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhData;
            wait_idx   = idx_inc[2:0];
          end else begin
            fin = 1'b1;
          end
        end
        rtpb_pkg::PhRlen: begin
          if (timed) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusTimeout;
          end else if (item_i.port_in > {4'h0, rtpb_pkg::MaxPayload}) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusBadLen;
          end else begin
            rc_new = item_i.port_in[3:0];
            if (item_i.port_in == 8'h00) begin
              fin = 1'b1;
            end else begin
              go_wait    = 1'b1;
              wait_phase = rtpb_pkg::PhRdata;
            end
          end
        end
        rtpb_pkg::PhRdata: begin
          rs_new = (rs_q & ~(64'hFF << sh)) | ({56'h0, item_i.port_in} << sh);
          if (timed) begin
            fin    = 1'b1;
            fin_st = rtpb_pkg::StatusTimeout;
          end else if (idx_inc < rc_q) begin
            go_wait    = 1'b1;
            wait_phase = rtpb_pkg::PhRdata;
            wait_idx   = idx_inc[2:0];
          end else begin
            fin = 1'b1;
          end
        end
        default: begin
          port_byte = 8'h00;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    cd_d         = cd_q;
    addr_d       = addr_q;
    payload_d    = payload_q;
    len_d        = len_q;
    mon_d        = mon_q;
    retry_used_d = retry_used_q;
    rs_d         = rs_q;
    rc_d         = rc_q;
    last_wait_d  = last_wait_q;
    if (step_i) begin
      if (!busy) begin
        phase_d = rtpb_pkg::PhIdle;
        if (is_req) begin
          addr_d       = item_i.request_address;
          payload_d    = item_i.request_payload;
          mon_d        = (item_i.cmd == rtpb_pkg::CmdMonitor);
          len_d        = (item_i.cmd == rtpb_pkg::CmdMonitor) ? 4'd0 : len_sat;
          retry_used_d = 1'b0;
          rs_d         = 64'h0;
          rc_d         = 4'd0;
          phase_d      = rtpb_pkg::PhAddr;
          idx_d        = 3'd0;
          cd_d         = timeout_ticks_i;
        end
      end else begin
        cd_d = cd_new;
        if (fire) begin
          last_wait_d = cd_new;
          rc_d        = rc_new;
          rs_d        = rs_new;
          if (go_wait) begin
            phase_d = wait_phase;
            idx_d   = wait_idx;
            cd_d    = timeout_ticks_i;
          end else if (retry) begin
            retry_used_d = 1'b1;
            rs_d         = 64'h0;
            rc_d         = 4'd0;
            phase_d      = rtpb_pkg::PhAddr;
            idx_d        = 3'd0;
            cd_d         = timeout_ticks_i;
          end else if (fin) begin
            phase_d = rtpb_pkg::PhIdle;
            idx_d   = 3'd0;
          end
        end
      end
    end
  end

  // Result of this tick.
  always_comb begin
    result_o                = '0;
    result_o.wait_remaining = last_wait_q;
    if (!busy) begin
      result_o.drive_port = 1'b1;
      result_o.busy_res   = is_req;
    end else begin
      result_o.busy_res   = 1'b1;
      result_o.drive_port = (phase_q inside {rtpb_pkg::PhAddr, rtpb_pkg::PhLen,
                                             rtpb_pkg::PhData});
      if (fire) begin
        result_o.wait_remaining = cd_new;
        result_o.wait_pulse     = 1'b1;
        result_o.port_out       = port_byte;
        if (fin && !retry) begin
          result_o.busy_res = 1'b0;
          result_o.done_res = 1'b1;
          result_o.status   = fin_st;
          if ((fin_st == rtpb_pkg::StatusOk) && mon_q) begin
            result_o.reply_length = rc_new;
            result_o.reply_data   = rs_new;
          end
        end
      end
    end
    result_o.interrupt_line = result_o.busy_res;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= rtpb_pkg::PhIdle;
      idx_q        <= 3'd0;
      cd_q         <= 16'd0;
      addr_q       <= 32'h0;
      payload_q    <= 64'h0;
      len_q        <= 4'd0;
      mon_q        <= 1'b0;
      retry_used_q <= 1'b0;
      rs_q         <= 64'h0;
      rc_q         <= 4'd0;
      last_wait_q  <= 16'd0;
    end else begin
      phase_q      <= phase_d;
      idx_q        <= idx_d;
      cd_q         <= cd_d;
      addr_q       <= addr_d;
      payload_q    <= payload_d;
      len_q        <= len_d;
      mon_q        <= mon_d;
      retry_used_q <= retry_used_d;
      rs_q         <= rs_d;
      rc_q         <= rc_d;
      last_wait_q  <= last_wait_d;
    end
  end

`ifndef SYNTHESIS
  // A wait never starts while the transaction also finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(go_wait && fin))
    else $error("rtpb_fsm: wait start and finish together");

  // A retry leaves the machine sending the first address byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_i && busy && fire && retry) |=>
                   (phase_q == rtpb_pkg::PhAddr) && (idx_q == 3'd0) && retry_used_q)
    else $error("rtpb_fsm: retry did not restart the address bytes");

  // The reply count never exceeds the largest reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rc_q <= rtpb_pkg::MaxPayload)
    else $error("rtpb_fsm: reply count out of range");
`endif

endmodule

// ===== rtl/core/request_to_parallel_port_bridge_top.sv =====
// Top level of the request to parallel-port bridge: input, state machine and result register.
// A transaction is held in the input register and, once the result register is free or being
// emptied, is stepped through the state machine into the result register.
// Throughput: one transaction per cycle while the output does not stall, set by the state
// machine step between the input register and the result register.
// Reset clears the valid flags and the state machine and loads the register defaults
// (timeout 1000 ticks, monitor retry enabled).
module request_to_parallel_port_bridge_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] request_address_i,
  input  logic [3:0]  request_length_i,
  input  logic [63:0] request_payload_i,
  input  logic        strobe_n_i,
  input  logic [7:0]  port_in_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  port_out_o,
  output logic        drive_port_o,
  output logic        wait_pulse_o,
  output logic        interrupt_line_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [3:0]  reply_length_o,
  output logic [63:0] reply_data_o,
  output logic [15:0] wait_remaining_o
);

  logic [15:0]     timeout_q;
  logic            retry_en_q;
  rtpb_pkg::req_t  in_q, in_d;
  logic            in_valid_q, in_valid_d;
  rtpb_pkg::res_t  out_q;
  rtpb_pkg::res_t  step_res;
  logic            out_valid_q, out_valid_d;
  logic            advance;
  logic            in_take;

  // Handshake control.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_d.cmd             = cmd_i;
    in_d.request_address = request_address_i;
    in_d.request_length  = request_length_i;
    in_d.request_payload = request_payload_i;
    in_d.strobe_n        = strobe_n_i;
    in_d.port_in         = port_in_i;
  end

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= rtpb_pkg::TimeoutReset;
      retry_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rtpb_pkg::CfgTimeout: timeout_q  <= cfg_data_i;
        rtpb_pkg::CfgRetry:   retry_en_q <= cfg_data_i[0];
        default:              timeout_q  <= timeout_q;
      endcase
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  rtpb_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .item_i          (in_q),
    .timeout_ticks_i (timeout_q),
    .retry_en_i      (retry_en_q),
    .result_o        (step_res)
  );

  assign out_valid_o      = out_valid_q;
  assign port_out_o       = out_q.port_out;
  assign drive_port_o     = out_q.drive_port;
  assign wait_pulse_o     = out_q.wait_pulse;
  assign interrupt_line_o = out_q.interrupt_line;
  assign busy_res_o       = out_q.busy_res;
  assign done_res_o       = out_q.done_res;
  assign status_o         = out_q.status;
  assign reply_length_o   = out_q.reply_length;
  assign reply_data_o     = out_q.reply_data;
  assign wait_remaining_o = out_q.wait_remaining;

`ifndef SYNTHESIS
  // The input side only stalls while a finished result waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("bridge: input stalled without a blocked result");

  // A step always leaves a result to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> out_valid_q)
    else $error("bridge: stepped transaction produced no result");

  // A finishing result is never busy, and the interrupt follows busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> !(out_q.done_res && out_q.busy_res) &&
                   (out_q.interrupt_line == out_q.busy_res))
    else $error("bridge: inconsistent busy, done or interrupt");

  // Status and reply fields are only set on a finishing result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_q.done_res) |->
                   (out_q.status == 2'd0) && (out_q.reply_length == 4'd0))
    else $error("bridge: status outside a finishing result");
`endif

endmodule
